// File: hdl/source_text_tokenizer_core_macros.svh
// assertion macros shared by the tokenizer modules
`ifndef SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define STT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define STT_ASSERT(lbl, prop, msg)

`define STT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/stt_pkg.sv
package stt_pkg;

	localparam int POSITION_BITS_DEF = 16;

	localparam logic OP_END = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ESC  = 2'd1;
	localparam logic [1:0] ST_UNCLOSED = 2'd2;
	localparam logic [1:0] ST_END      = 2'd3;

	localparam logic [3:0] CLS_LPAREN   = 4'd0;
	localparam logic [3:0] CLS_INT      = 4'd1;
	localparam logic [3:0] CLS_RPAREN   = 4'd2;
	localparam logic [3:0] CLS_COMMA    = 4'd3;
	localparam logic [3:0] CLS_DOT      = 4'd4;
	localparam logic [3:0] CLS_LESS     = 4'd5;
	localparam logic [3:0] CLS_GREATER  = 4'd6;
	localparam logic [3:0] CLS_LBRACKET = 4'd7;
	localparam logic [3:0] CLS_RBRACKET = 4'd8;
	localparam logic [3:0] CLS_LBRACE   = 4'd9;
	localparam logic [3:0] CLS_RBRACE   = 4'd10;
	localparam logic [3:0] CLS_EQUAL    = 4'd11;
	localparam logic [3:0] CLS_PLUS     = 4'd12;
	localparam logic [3:0] CLS_MINUS    = 4'd13;
	localparam logic [3:0] CLS_STRING   = 4'd14;
	localparam logic [3:0] CLS_IDENT    = 4'd15;

	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_SQUOTE   = 8'h27;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_LESS     = 8'h3C;
	localparam logic [7:0] CH_EQUAL    = 8'h3D;
	localparam logic [7:0] CH_GREATER  = 8'h3E;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_B        = 8'h62;
	localparam logic [7:0] CH_N        = 8'h6E;
	localparam logic [7:0] CH_R        = 8'h72;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	typedef struct packed {
		logic       opcode;
		logic [7:0] ch;
	} req_item_t;

	typedef struct packed {
		logic        char_valid;
		logic [7:0]  out_char;
		logic        token_first;
		logic        token_last;
		logic [3:0]  token_class;
		logic [1:0]  status;
		logic [15:0] error_position;
	} tok_item_t;

	typedef struct packed {
		logic       in_string;
		logic       in_comment;
		logic       escape_seen;
		logic [1:0] open_quote;
		logic [7:0] held_char;
		logic       held_valid;
		logic       held_is_first;
		logic       token_length_one;
		logic       all_digits;
		logic [7:0] first_char;
		logic       halted;
	} stt_state_t;

	typedef struct packed {
		logic [1:0] n;
		tok_item_t  a;
		tok_item_t  b;
	} stt_push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_mark(input logic [7:0] c);
		logic m;
		unique case (c)
			CH_LPAREN, CH_RPAREN, CH_COMMA, CH_LESS, CH_GREATER,
			CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE,
			CH_EQUAL, CH_PLUS, CH_MINUS, CH_SEMI: m = 1'b1;
			default: m = 1'b0;
		endcase
		return m;
	endfunction

	// bit 8 set when the escape is known
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			CH_N:      r = {1'b1, CH_LF};
			CH_T:      r = {1'b1, CH_TAB};
			CH_R:      r = {1'b1, CH_CR};
			CH_SQUOTE: r = {1'b1, CH_SQUOTE};
			CH_DQUOTE: r = {1'b1, CH_DQUOTE};
			CH_B:      r = {1'b1, CH_BS};
			default:   r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] kind_of(input logic len_one, input logic digits,
		input logic [7:0] first, input logic [7:0] last);
		logic [3:0] k;
		k = CLS_IDENT;
		if (((first == CH_DQUOTE) && (last == CH_DQUOTE)) ||
			((first == CH_SQUOTE) && (last == CH_SQUOTE))) begin
			k = CLS_STRING;
		end
		if (len_one) begin
			unique case (last)
				CH_RPAREN:   k = CLS_RPAREN;
				CH_COMMA:    k = CLS_COMMA;
				CH_DOT:      k = CLS_DOT;
				CH_LESS:     k = CLS_LESS;
				CH_GREATER:  k = CLS_GREATER;
				CH_LBRACKET: k = CLS_LBRACKET;
				CH_RBRACKET: k = CLS_RBRACKET;
				CH_LBRACE:   k = CLS_LBRACE;
				CH_RBRACE:   k = CLS_RBRACE;
				CH_EQUAL:    k = CLS_EQUAL;
				CH_PLUS:     k = CLS_PLUS;
				CH_MINUS:    k = CLS_MINUS;
				default:     k = k;
			endcase
		end
		if (digits) begin
			k = CLS_INT;
		end
		if (len_one && (last == CH_LPAREN)) begin
			k = CLS_LPAREN;
		end
		return k;
	endfunction

endpackage

// File: hdl/stt_ctrl.sv
`include "source_text_tokenizer_core_macros.svh"

module stt_ctrl #(
	parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  stt_pkg::req_item_t item,
	output stt_pkg::stt_push_t push
);
	import stt_pkg::*;

	localparam logic [1:0] OQ_NONE   = 2'd0;
	localparam logic [1:0] OQ_DOUBLE = 2'd1;
	localparam logic [1:0] OQ_SINGLE = 2'd2;

	localparam stt_state_t STATE_RESET = '{
		in_string: 1'b0, in_comment: 1'b0, escape_seen: 1'b0, open_quote: OQ_NONE,
		held_char: 8'h00, held_valid: 1'b0, held_is_first: 1'b0,
		token_length_one: 1'b0, all_digits: 1'b1, first_char: 8'h00, halted: 1'b0
	};

	stt_state_t st_q, st_d, st_ap, st_fl;
	logic [POSITION_BITS-1:0] pos_q, pos_d, pos_inc, err_pos;
	logic [7:0] c, ap_c, ap_first;
	logic [8:0] esc;
	logic ap_len1, ap_digits, is_quote, close_match;
	logic [1:0] end_status, fl_status;
	tok_item_t res_held, res_flush, res_tail, res_mark, res_err, res_end;
	tok_item_t e0, e1;
	logic v0, v1;

	assign c        = item.ch;
	assign pos_inc  = pos_q + POSITION_BITS'(1);
	assign err_pos  = pos_inc - POSITION_BITS'(3);
	assign esc      = esc_map(c);
	assign ap_c     = st_q.escape_seen ? esc[7:0] : c;
	assign ap_len1  = !st_q.held_valid;
	assign ap_first = st_q.held_valid ? st_q.first_char : ap_c;
	assign ap_digits = (st_q.held_valid ? st_q.all_digits : 1'b1) & is_digit(ap_c);
	assign is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
	assign close_match = ((st_q.open_quote == OQ_DOUBLE) && (c == CH_DQUOTE)) ||
		((st_q.open_quote == OQ_SINGLE) && (c == CH_SQUOTE));
	assign end_status = st_q.in_string ? ST_UNCLOSED : ST_END;
	assign fl_status  = (item.opcode == OP_END) ? end_status : ST_OK;

	always_comb begin
		res_held = '0;
		res_held.char_valid  = 1'b1;
		res_held.out_char    = st_q.held_char;
		res_held.token_first = st_q.held_is_first;

		res_flush = res_held;
		res_flush.token_last  = 1'b1;
		res_flush.token_class = kind_of(st_q.token_length_one, st_q.all_digits,
			st_q.first_char, st_q.held_char);
		res_flush.status = fl_status;

		res_tail = '0;
		res_tail.char_valid  = 1'b1;
		res_tail.out_char    = c;
		res_tail.token_first = ap_len1;
		res_tail.token_last  = 1'b1;
		res_tail.token_class = kind_of(ap_len1, ap_digits, ap_first, c);

		res_mark = '0;
		res_mark.char_valid  = 1'b1;
		res_mark.out_char    = c;
		res_mark.token_first = 1'b1;
		res_mark.token_last  = 1'b1;
		res_mark.token_class = kind_of(1'b1, is_digit(c), c, c);

		res_err = '0;
		res_err.status         = ST_BAD_ESC;
		res_err.error_position = 16'(err_pos);

		res_end = '0;
		res_end.status = st_q.halted ? ST_END : end_status;
	end

	// state after appending a character, and after closing the token
	always_comb begin
		st_ap = st_q;
		st_ap.held_char        = ap_c;
		st_ap.held_valid       = 1'b1;
		st_ap.held_is_first    = ap_len1;
		st_ap.token_length_one = ap_len1;
		st_ap.all_digits       = ap_digits;
		st_ap.first_char       = ap_first;

		st_fl = st_q;
		st_fl.held_char        = 8'h00;
		st_fl.held_valid       = 1'b0;
		st_fl.held_is_first    = 1'b0;
		st_fl.token_length_one = 1'b0;
		st_fl.all_digits       = 1'b1;
		st_fl.first_char       = 8'h00;
	end

	always_comb begin
		st_d  = st_q;
		pos_d = pos_q;
		v0 = 1'b0;
		v1 = 1'b0;
		e0 = res_held;
		e1 = res_tail;
		if (take) begin
			if (item.opcode == OP_END) begin
				st_d  = STATE_RESET;
				pos_d = '0;
				v0 = 1'b1;
				e0 = (!st_q.halted && st_q.held_valid) ? res_flush : res_end;
			end else if (!st_q.halted) begin
				pos_d = pos_inc;
				priority if (c == CH_HASH) begin
					st_d.in_comment = 1'b1;
				end else if (c == CH_BSLASH) begin
					st_d.escape_seen = 1'b1;
				end else if (st_q.in_comment && st_q.escape_seen && (c == CH_N)) begin
					st_d.in_comment = 1'b0;
				end else if (st_q.escape_seen) begin
					if (!esc[8]) begin
						v0 = 1'b1;
						e0 = res_err;
						st_d.held_valid = 1'b0;
						st_d.halted     = 1'b1;
					end else if (!st_q.in_comment) begin
						v0 = st_q.held_valid;
						st_d = st_ap;
					end
					st_d.escape_seen = 1'b0;
				end else if (st_q.in_comment) begin
					st_d = st_q;
				end else if (is_quote && !st_q.in_string) begin
					v0 = st_q.held_valid;
					st_d = st_ap;
					st_d.in_string  = 1'b1;
					st_d.open_quote = (c == CH_DQUOTE) ? OQ_DOUBLE : OQ_SINGLE;
				end else if (st_q.in_string && close_match) begin
					v0 = st_q.held_valid;
					v1 = 1'b1;
					st_d = st_fl;
					st_d.in_string  = 1'b0;
					st_d.open_quote = OQ_NONE;
				end else if (!st_q.in_string && is_mark(c)) begin
					v0 = st_q.held_valid;
					e0 = res_flush;
					v1 = 1'b1;
					e1 = res_mark;
					st_d = st_fl;
				end else if (!st_q.in_string && is_space(c)) begin
					v0 = st_q.held_valid;
					e0 = res_flush;
					st_d = st_fl;
				end else begin
					v0 = st_q.held_valid;
					st_d = st_ap;
				end
			end
		end
	end

	always_comb begin
		push.n = {1'b0, v0} + {1'b0, v1};
		push.a = v0 ? e0 : e1;
		push.b = e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= STATE_RESET;
			pos_q <= '0;
		end else begin
			st_q  <= st_d;
			pos_q <= pos_d;
		end
	end

	`STT_ASSERT(a_halt_no_held, st_q.halted |-> !st_q.held_valid, "held char while halted")
	`STT_ASSERT(a_quote_track, st_q.in_string == (st_q.open_quote != OQ_NONE), "quote state mismatch")
	`STT_ASSERT_NEXT(a_end_clears, take && (item.opcode == OP_END), (st_q == STATE_RESET) && (pos_q == '0), "end of text left state behind")

endmodule

// File: hdl/stt_outq.sv
`include "source_text_tokenizer_core_macros.svh"

module stt_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  stt_pkg::stt_push_t push,
	output logic               full,
	output logic               tok_valid,
	input  logic               tok_stall,
	output stt_pkg::tok_item_t tok_data
);
	import stt_pkg::*;

	tok_item_t  mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign tok_valid = cnt_q != 3'd0;
	assign tok_data  = mem_q[rd_q];
	assign pop       = tok_valid && !tok_stall;
	// room must remain for a two-result request
	assign full      = cnt_q > 3'd2;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.n;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.n} - {2'b00, pop};
		end
	end

	`STT_ASSERT(a_push_room, (push.n != 2'd0) |-> (cnt_q <= 3'd2), "push into a full result queue")
	`STT_ASSERT(a_cnt_max, cnt_q <= 3'd4, "result queue count out of range")
	`STT_ASSERT(a_cnt_track, $past(arst_n) |-> (cnt_q == $past(cnt_q) + {1'b0, $past(push.n)} - {2'b00, $past(pop)}), "result queue count drift")

endmodule

// File: hdl/source_text_tokenizer_core.sv
// streaming source text tokenizer
// request channel (req_valid, req_stall, req_data): one source byte per
// request, or an end-of-text marker with opcode set
// result channel (tok_valid, tok_stall, tok_data): token characters, each
// marked first and/or last, with the token kind on the last one, plus
// status-only results for a bad escape and for end of text
// the last character of a token is held back until the next byte or end of
// text shows where the token stops
// each accepted request writes its results into the result queue
// throughput: one request per cycle while req_stall is low and each yields
// at most one result; a request that yields two results (closing quote,
// single-char mark) puts both into the four-entry result queue that the result port drains
// req_stall rises while the queue holds more than two results, so a stall
// on tok_stall backs up into req_stall after at most four results
// reset clears the tokenizer state, the position counter and the queue;
// end of text also returns the tokenizer state to its reset values
module source_text_tokenizer_core #(
	parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  stt_pkg::req_item_t req_data,
	output logic               tok_valid,
	input  logic               tok_stall,
	output stt_pkg::tok_item_t tok_data
);
	import stt_pkg::*;

	stt_push_t push;
	logic      take;

	assign take = req_valid && !req_stall;

	stt_ctrl #(
		.POSITION_BITS(POSITION_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (req_data),
		.push   (push)
	);

	stt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (req_stall),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

endmodule

// File: tb/tb_source_text_tokenizer_core.sv
`timescale 1ns / 1ps

module tb_source_text_tokenizer_core;
	import stt_pkg::*;

	localparam logic       OP_CHAR      = 1'b0;
	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
	localparam logic [1:0] QUOTE_SINGLE = 2'd2;
	localparam int         IDLE_PCT     = 26;
	localparam int         WORK_TARGET  = 1300;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_data = '0;
	logic      tok_valid;
	logic      tok_stall = 1'b0;
	tok_item_t tok_data;

	source_text_tokenizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data(tok_data)
	);

	req_item_t pending_requests[$];
	tok_item_t expected_tokens[$];
	int        work_items = 0;
	int        mismatch_count = 0;
	int        cycle_count = 0;
	logic      req_taken = 1'b0;

	// lexer state tracked alongside the block
	logic        in_str, in_cmt, esc_open, halted;
	logic [1:0]  quote_kind;
	logic [7:0]  held_byte, lead_char;
	logic        held_ok, held_lead, one_char, digits_only;
	logic [15:0] byte_count;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic is_digit_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic mark_char(input logic [7:0] c);
		case (c)
			CH_LPAREN, CH_RPAREN, CH_COMMA, CH_LESS, CH_GREATER, CH_LBRACKET,
			CH_RBRACKET, CH_LBRACE, CH_RBRACE, CH_EQUAL, CH_PLUS, CH_MINUS,
			CH_SEMI: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// bit 8 marks a known escape
	function automatic logic [8:0] escape_char(input logic [7:0] c);
		case (c)
			CH_N:      return {1'b1, CH_LF};
			CH_T:      return {1'b1, CH_TAB};
			CH_R:      return {1'b1, CH_CR};
			CH_B:      return {1'b1, CH_BS};
			CH_SQUOTE: return {1'b1, CH_SQUOTE};
			CH_DQUOTE: return {1'b1, CH_DQUOTE};
			default:   return '0;
		endcase
	endfunction

	function automatic logic [3:0] token_kind(input logic [7:0] last);
		logic [3:0] k;
		if (one_char && last == CH_LPAREN) begin
			k = CLS_LPAREN;
		end else if (digits_only) begin
			k = CLS_INT;
		end else begin
			k = CLS_IDENT;
			if ((lead_char == CH_DQUOTE && last == CH_DQUOTE) ||
				(lead_char == CH_SQUOTE && last == CH_SQUOTE)) begin
				k = CLS_STRING;
			end
			if (one_char) begin
				case (last)
					CH_RPAREN:   k = CLS_RPAREN;
					CH_COMMA:    k = CLS_COMMA;
					CH_DOT:      k = CLS_DOT;
					CH_LESS:     k = CLS_LESS;
					CH_GREATER:  k = CLS_GREATER;
					CH_LBRACKET: k = CLS_LBRACKET;
					CH_RBRACKET: k = CLS_RBRACKET;
					CH_LBRACE:   k = CLS_LBRACE;
					CH_RBRACE:   k = CLS_RBRACE;
					CH_EQUAL:    k = CLS_EQUAL;
					CH_PLUS:     k = CLS_PLUS;
					CH_MINUS:    k = CLS_MINUS;
					default:     k = k;
				endcase
			end
		end
		return k;
	endfunction

	task automatic clear_lexer();
		in_str = 1'b0;
		in_cmt = 1'b0;
		esc_open = 1'b0;
		quote_kind = QUOTE_NONE;
		held_byte = '0;
		held_ok = 1'b0;
		held_lead = 1'b0;
		one_char = 1'b0;
		digits_only = 1'b1;
		lead_char = '0;
		byte_count = '0;
		halted = 1'b0;
	endtask

	task automatic push_expected(input logic v, input logic [7:0] c, input logic f,
		input logic l, input logic [3:0] k, input logic [1:0] s, input logic [15:0] p);
		expected_tokens.insert(expected_tokens.size(), tok_item_t'{v, c, f, l, k, s, p});
	endtask

	task automatic add_char(input logic [7:0] c);
		if (held_ok) begin
			push_expected(1'b1, held_byte, held_lead, 1'b0, '0, ST_OK, '0);
			held_lead = 1'b0;
			one_char = 1'b0;
			if (!is_digit_char(c)) digits_only = 1'b0;
		end else begin
			held_lead = 1'b1;
			one_char = 1'b1;
			lead_char = c;
			digits_only = is_digit_char(c);
		end
		held_byte = c;
		held_ok = 1'b1;
	endtask

	task automatic close_token(input logic [1:0] st);
		if (held_ok)
			push_expected(1'b1, held_byte, held_lead, 1'b1, token_kind(held_byte), st, '0);
		held_ok = 1'b0;
		held_lead = 1'b0;
		held_byte = '0;
		one_char = 1'b0;
		digits_only = 1'b1;
		lead_char = '0;
	endtask

	task automatic lex_byte(input req_item_t r);
		logic [7:0] c;
		logic [8:0] esc;
		logic       closes;
		c = r.ch;
		closes = in_str && ((quote_kind == QUOTE_DOUBLE && c == CH_DQUOTE) ||
			(quote_kind == QUOTE_SINGLE && c == CH_SQUOTE));
		if (r.opcode == OP_END) begin
			if (halted)
				push_expected(1'b0, '0, 1'b0, 1'b0, '0, ST_END, '0);
			else if (held_ok)
				close_token(in_str ? ST_UNCLOSED : ST_END);
			else
				push_expected(1'b0, '0, 1'b0, 1'b0, '0, in_str ? ST_UNCLOSED : ST_END, '0);
			clear_lexer();
		end else if (!halted) begin
			byte_count = byte_count + 16'd1;
			if (c == CH_HASH) begin
				in_cmt = 1'b1;
			end else if (c == CH_BSLASH) begin
				esc_open = 1'b1;
			end else if (in_cmt && esc_open && c == CH_N) begin
				// escape stays open after the comment closes
				in_cmt = 1'b0;
			end else if (esc_open) begin
				esc_open = 1'b0;
				esc = escape_char(c);
				if (!esc[8]) begin
					push_expected(1'b0, '0, 1'b0, 1'b0, '0, ST_BAD_ESC, byte_count - 16'd3);
					held_ok = 1'b0;
					halted = 1'b1;
				end else if (!in_cmt) begin
					add_char(esc[7:0]);
				end
			end else if (!in_cmt) begin
				if (!in_str && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
					in_str = 1'b1;
					quote_kind = (c == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
					add_char(c);
				end else if (closes) begin
					in_str = 1'b0;
					quote_kind = QUOTE_NONE;
					add_char(c);
					close_token(ST_OK);
				end else if (!in_str && mark_char(c)) begin
					close_token(ST_OK);
					add_char(c);
					close_token(ST_OK);
				end else if (!in_str && blank_char(c)) begin
					close_token(ST_OK);
				end else begin
					add_char(c);
				end
			end
		end
	endtask

	task automatic note_mismatch(input string what, input tok_item_t want,
		input tok_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s: expected v=%0b c=%h f=%0b l=%0b k=%0d s=%0d p=%h",
				what, want.char_valid, want.out_char, want.token_first, want.token_last,
				want.token_class, want.status, want.error_position);
			$display("%s: actual   v=%0b c=%h f=%0b l=%0b k=%0d s=%0d p=%h",
				what, got.char_valid, got.out_char, got.token_first, got.token_last,
				got.token_class, got.status, got.error_position);
		end
	endtask

	task automatic check_token(input tok_item_t got);
		tok_item_t want;
		if (expected_tokens.size() == 0) begin
			note_mismatch("unexpected result", '0, got);
		end else begin
			want = expected_tokens.pop_front();
			if (got.char_valid !== want.char_valid || got.out_char !== want.out_char ||
				got.token_first !== want.token_first || got.token_last !== want.token_last ||
				got.token_class !== want.token_class || got.status !== want.status ||
				got.error_position !== want.error_position)
				note_mismatch("result mismatch", want, got);
		end
	endtask

	// idle roll, with a quiet stretch where neither side idles
	function automatic logic take_break();
		if (cycle_count >= 300 && cycle_count < 900) return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (tok_valid && !tok_stall) check_token(tok_data);
			req_taken = req_valid && !req_stall;
			if (req_taken) lex_byte(req_data);
		end else begin
			req_taken = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (pending_requests.size() != 0 && !take_break()) begin
					req_data <= pending_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			tok_stall <= take_break();
		end
	end

	task automatic push_byte(input logic [7:0] c);
		pending_requests.insert(pending_requests.size(), req_item_t'{OP_CHAR, c});
		work_items++;
	endtask

	task automatic push_end();
		pending_requests.insert(pending_requests.size(),
			req_item_t'{OP_END, 8'($urandom_range(255))});
		work_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	function automatic logic [7:0] name_char();
		case ($urandom_range(3))
			0: return 8'h61 + 8'($urandom_range(25));
			1: return 8'h41 + 8'($urandom_range(25));
			2: return 8'h80 + 8'($urandom_range(127));
			default: return 8'h5F;
		endcase
	endfunction

	function automatic logic [7:0] string_char();
		logic [7:0] c;
		do c = 8'($urandom_range(32, 126));
		while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH || c == CH_HASH);
		return c;
	endfunction

	function automatic logic [7:0] escape_letter(input logic with_n);
		string letters = "ntr'\"b";
		return letters[$urandom_range(with_n ? 0 : 1, 5)];
	endfunction

	function automatic logic [7:0] bad_escape_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (escape_char(c) != 0 || c == CH_BSLASH || c == CH_HASH);
		return c;
	endfunction

	function automatic logic [7:0] comment_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c == CH_BSLASH);
		return c;
	endfunction

	task automatic add_text();
		string      marks = "(),<>[]{}=+-;.";
		int         n_tok, pick, len;
		logic [7:0] q;
		n_tok = $urandom_range(1, 10);
		for (int i = 0; i < n_tok; i++) begin
			pick = $urandom_range(99);
			if (pick < 22) begin
				push_byte(name_char());
				len = $urandom_range(5);
				repeat (len)
					push_byte($urandom_range(2) == 0 ? CH_ZERO + 8'($urandom_range(9)) :
						name_char());
			end else if (pick < 36) begin
				len = $urandom_range(1, 5);
				repeat (len) push_byte(CH_ZERO + 8'($urandom_range(9)));
			end else if (pick < 52) begin
				push_byte(marks[$urandom_range(13)]);
			end else if (pick < 66) begin
				q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
				push_byte(q);
				len = $urandom_range(6);
				repeat (len) begin
					if ($urandom_range(4) == 0) begin
						push_byte(CH_BSLASH);
						push_byte(escape_letter(1'b1));
					end else begin
						push_byte(string_char());
					end
				end
				push_byte(q);
			end else if (pick < 74) begin
				push_byte(CH_HASH);
				len = $urandom_range(6);
				repeat (len) push_byte(comment_byte());
				if ($urandom_range(2) == 0) begin
					push_byte(CH_BSLASH);
					push_byte(escape_letter(1'b0));
				end
				push_byte(CH_BSLASH);
				push_byte(CH_N);
				if ($urandom_range(5) == 0) push_byte(CH_BSLASH);
				push_byte(escape_letter(1'b1));
			end else if (pick < 84) begin
				push_byte(8'($urandom_range(255)));
			end else if (pick < 87) begin
				push_byte(CH_BSLASH);
				push_byte(bad_escape_byte());
				// halted block drops these
				len = $urandom_range(3);
				repeat (len) pending_requests.insert(pending_requests.size(),
					req_item_t'{OP_CHAR, 8'($urandom_range(255))});
				push_end();
				return;
			end else if (pick < 90) begin
				push_byte($urandom_range(1) ? CH_DQUOTE : CH_SQUOTE);
				len = $urandom_range(4);
				repeat (len) push_byte(string_char());
				push_end();
				return;
			end
			if ($urandom_range(9) < 7) begin
				len = $urandom_range(1, 2);
				repeat (len)
					push_byte($urandom_range(4) == 0 ? CH_TAB + 8'($urandom_range(4)) :
						CH_SPACE);
			end
		end
		push_end();
	endtask

	initial begin
		clear_lexer();
		// byte extremes, then a mark closing the token
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("+");
		// backslash before hash, escape inside comment, repeated backslash
		push_text("\\#\\t\\n\\\\b.");
		push_end();
		push_end();
		// hash inside a string, string left open at end of text
		push_text("\"#\\n\"");
		push_end();
		// bad escape near the start, later bytes dropped
		push_text("\\qz");
		push_end();
		push_text(".(;");
		push_end();
		while (work_items < WORK_TARGET) add_text();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_tokens.size() == 0) begin
			$display("PASS source_text_tokenizer_core");
		end else begin
			$display("FAIL source_text_tokenizer_core");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("FAIL source_text_tokenizer_core");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_ctrl.sv
hdl/stt_outq.sv
hdl/source_text_tokenizer_core.sv
tb/tb_source_text_tokenizer_core.sv
